// ----- design/siphash_2_4_keyed_hash_defines.svh -----
// assertion macros shared by the siphash checker
`ifndef SIPHASH_2_4_KEYED_HASH_DEFINES_SVH
`define SIPHASH_2_4_KEYED_HASH_DEFINES_SVH

// property checked every clock, off while reset is asserted
`define SIP24_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// antecedent in one cycle, consequent in the next
`define SIP24_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- design/sip24_pkg.sv -----
// shared types, constants and helpers of the siphash-2-4 engine
package sip24_pkg;

	localparam logic [63:0] IV0       = 64'h736f6d6570736575;
	localparam logic [63:0] IV1       = 64'h646f72616e646f6d;
	localparam logic [63:0] IV2       = 64'h6c7967656e657261;
	localparam logic [63:0] IV3       = 64'h7465646279746573;
	localparam logic [63:0] FINAL_XOR = 64'h00000000000000ff;

	localparam logic [7:0] WORD_BYTES = 8'd8;
	localparam logic [2:0] RND_ABSORB_LAST = 3'd1;
	localparam logic [2:0] RND_FINAL_LAST  = 3'd5;

	localparam logic CFG_KEY_LOW  = 1'b0;
	localparam logic CFG_KEY_HIGH = 1'b1;

	typedef struct packed {
		logic [63:0] v0;
		logic [63:0] v1;
		logic [63:0] v2;
		logic [63:0] v3;
	} sip_state_t;

	typedef struct packed {
		logic        valid;
		logic [63:0] hash;
	} sip24_res_t;

	// keeps the low tail bytes of the seven below the length byte
	function automatic logic [55:0] tail_mask(input logic [2:0] tail);
		logic [55:0] m;
		m = '0;
		for (int i = 0; i < 7; i++) begin
			if (3'(i) < tail) begin
				m[8*i +: 8] = 8'hff;
			end
		end
		return m;
	endfunction

endpackage

// ----- design/sip24_round.sv -----
// one sipround on the four state words
module sip24_round import sip24_pkg::*; (
	input  sip_state_t v_in,
	output sip_state_t v_out
);

	logic [63:0] a1, b1, c1, d1;
	logic [63:0] a2, b2, c2, d2;

	always_comb begin
		a1 = v_in.v0 + v_in.v1;
		b1 = {v_in.v1[50:0], v_in.v1[63:51]} ^ a1;
		c1 = v_in.v2 + v_in.v3;
		d1 = {v_in.v3[47:0], v_in.v3[63:48]} ^ c1;
		// a is rotated by 32 before the second add
		a2 = {a1[31:0], a1[63:32]} + d1;
		d2 = {d1[42:0], d1[63:43]} ^ a2;
		c2 = c1 + b1;
		b2 = {b1[46:0], b1[63:47]} ^ c2;
		v_out.v0 = a2;
		v_out.v1 = b2;
		v_out.v2 = {c2[31:0], c2[63:32]};
		v_out.v3 = d2;
	end

endmodule

// ----- design/sip24_core.sv -----
// state words, length count and round sequencer around the shared sipround
module sip24_core import sip24_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic [63:0] key_low,
	input  logic [63:0] key_high,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [63:0] data_word,
	input  logic [2:0]  tail_bytes,
	input  logic        last_word,
	output sip24_res_t  res,
	input  logic        res_ready
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ROUND,
		ST_DONE
	} state_t;

	state_t      state_q;
	sip_state_t  v_q;
	sip_state_t  v_rnd;
	sip_state_t  v_init;
	sip_state_t  v_load;
	sip_state_t  v_step;
	logic [63:0] msg_q;
	logic        last_q;
	logic [2:0]  rnd_q;
	logic [7:0]  byte_total_q;
	logic        in_msg_q;
	logic [7:0]  len_total;
	logic [63:0] pad_word;

	sip24_round u_round (
		.v_in  (v_q),
		.v_out (v_rnd)
	);

	always_comb begin
		if (in_msg_q) begin
			v_init = v_q;
		end else begin
			v_init.v0 = key_low ^ IV0;
			v_init.v1 = key_high ^ IV1;
			v_init.v2 = key_low ^ IV2;
			v_init.v3 = key_high ^ IV3;
		end
		len_total = (in_msg_q ? byte_total_q : 8'd0)
			+ (last_word ? {5'd0, tail_bytes} : WORD_BYTES);
		// last word: length byte on top, tail bytes below, rest zero
		pad_word = last_word ? {len_total, data_word[55:0] & tail_mask(tail_bytes)}
			: data_word;
		v_load    = v_init;
		v_load.v3 = v_init.v3 ^ pad_word;
		v_step    = v_rnd;
		if (rnd_q == RND_ABSORB_LAST) begin
			// end of absorb, finalization constant folded in on the last word
			v_step.v0 = v_rnd.v0 ^ msg_q;
			v_step.v2 = v_rnd.v2 ^ (last_q ? FINAL_XOR : 64'd0);
		end
	end

	assign in_ready  = (state_q == ST_IDLE);
	assign res.valid = (state_q == ST_DONE);
	assign res.hash  = v_q.v0 ^ v_q.v1 ^ v_q.v2 ^ v_q.v3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			v_q          <= '0;
			msg_q        <= '0;
			last_q       <= 1'b0;
			rnd_q        <= '0;
			byte_total_q <= '0;
			in_msg_q     <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						v_q          <= v_load;
						msg_q        <= pad_word;
						last_q       <= last_word;
						rnd_q        <= '0;
						byte_total_q <= last_word ? 8'd0 : len_total;
						in_msg_q     <= !last_word;
						state_q      <= ST_ROUND;
					end
				end
				ST_ROUND: begin
					rnd_q <= rnd_q + 3'd1;
					v_q   <= v_step;
					if (rnd_q == RND_ABSORB_LAST && !last_q) begin
						state_q <= ST_IDLE;
					end
					if (rnd_q == RND_FINAL_LAST) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (res_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// ----- design/siphash_2_4_keyed_hash.sv -----
// SipHash-2-4 engine: one sipround unit reused each cycle under a small sequencer.
// A full word is accepted, then runs two rounds; the last word is accepted, runs two
// absorb rounds and four finalization rounds, and its hash is handed off to the
// output register. The key is held in two registers, sampled when a message
// starts; the byte count is kept internally. Results sit in an output register,
// so a new message can start while a hash waits to be taken.
module siphash_2_4_keyed_hash import sip24_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [63:0] s_axis_tdata,   // data_word
	input  logic [2:0]  s_axis_tuser,   // tail_bytes
	input  logic        s_axis_tlast,   // last_word
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [63:0] m_axis_tdata,   // hash_value
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [63:0] cfg_data
);

	logic [63:0] key_low_q;
	logic [63:0] key_high_q;
	logic        out_valid_q;
	logic [63:0] out_data_q;
	sip24_res_t  res;
	logic        res_ready;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_low_q  <= '0;
			key_high_q <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_KEY_LOW:  key_low_q  <= cfg_data;
				CFG_KEY_HIGH: key_high_q <= cfg_data;
				default: ;
			endcase
		end
	end

	sip24_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.key_low    (key_low_q),
		.key_high   (key_high_q),
		.in_valid   (s_axis_tvalid),
		.in_ready   (s_axis_tready),
		.data_word  (s_axis_tdata),
		.tail_bytes (s_axis_tuser),
		.last_word  (s_axis_tlast),
		.res        (res),
		.res_ready  (res_ready)
	);

	assign res_ready = !out_valid_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			out_data_q  <= '0;
		end else if (res_ready) begin
			out_valid_q <= res.valid;
			if (res.valid) begin
				out_data_q <= res.hash;
			end
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

endmodule

// ----- design/sip24_checker.sv -----
// port-level checks of the siphash engine, bound to the top level
`include "siphash_2_4_keyed_hash_defines.svh"

module sip24_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [63:0] m_axis_tdata,
	input logic        cfg_ready
);

	// a stalled result stays put
	`SIP24_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready,
		m_axis_tvalid && $stable(m_axis_tdata), "result changed while stalled")

	// every word needs two rounds, so the input stays not ready after a transaction until both rounds are done
	`SIP24_ASSERT_NEXT(a_busy_first, s_axis_tvalid && s_axis_tready, !s_axis_tready,
		"input ready right after a transaction")
	`SIP24_ASSERT(a_busy_second, (s_axis_tvalid && s_axis_tready) |-> ##2 !s_axis_tready,
		"input ready one round after a transaction")

	// key registers always take a write
	`SIP24_ASSERT(a_cfg_ready, cfg_ready, "config port not ready")

endmodule

bind siphash_2_4_keyed_hash sip24_checker u_sip24_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.cfg_ready     (cfg_ready)
);
